>>> rtl/overwriting_ring_fifo_unit_macros.svh
// Assertion macros shared by the overwriting ring FIFO modules.
`ifndef OVERWRITING_RING_FIFO_UNIT_MACROS_SVH
`define OVERWRITING_RING_FIFO_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ORF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ORF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/orf_pkg.sv
// Shared types and codes for the overwriting ring FIFO.
package orf_pkg;

   localparam int MAX_DEPTH_DEF  = 256;
   localparam int WORD_WIDTH_DEF = 32;
   localparam int CSR_W          = 9;
   localparam int OP_W           = 2;
   localparam int STATUS_W       = 2;

   localparam logic [OP_W-1:0] OP_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RD_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO_WR  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd3;

   typedef enum logic [1:0] {
      SEL_ZERO  = 2'd0,
      SEL_EMPTY = 2'd1,
      SEL_MEM   = 2'd2
   } sel_type;

   typedef struct packed {
      logic                strobe;
      logic                mem_we;
      sel_type             sel;
      logic [STATUS_W-1:0] status;
   } cmd_type;

endpackage

>>> rtl/orf_ctrl.sv
// Ring FIFO controller: pointers, wrap flags, depth and command decode.
`include "overwriting_ring_fifo_unit_macros.svh"

module orf_ctrl #(
   parameter int  MAX_DEPTH = orf_pkg::MAX_DEPTH_DEF,
   localparam int IDX_W     = $clog2(MAX_DEPTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [orf_pkg::OP_W-1:0]    req_op,
   input  logic                        word_zero,
   input  logic                        csr_we,
   input  logic [orf_pkg::CSR_W-1:0]   csr_wdata,
   output orf_pkg::cmd_type            cmd,
   output logic [IDX_W-1:0]            mem_addr
);
   import orf_pkg::*;

   localparam int DW = (CSR_W > IDX_W + 1) ? CSR_W : IDX_W + 1;

   logic [IDX_W-1:0] head_ff, head_in, tail_ff, tail_in, last_ff, last_in;
   logic [IDX_W-1:0] head_next, tail_next, new_last;
   logic             wrapped_ff, wrapped_in, lapped_ff, lapped_in;
   logic             accept, empty, full;
   logic [DW-1:0]    depth_ext;

   // The block never holds start off, so busy is tied low.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign empty     = (head_ff == tail_ff) && !wrapped_ff;
   assign full      = (head_ff == tail_ff) && wrapped_ff;
   assign head_next = (head_ff == last_ff) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == last_ff) ? '0 : tail_ff + 1'b1;

   // Clamp the written depth into 1..MAX_DEPTH and keep it as a last index.
   assign depth_ext = DW'(csr_wdata);
   always_comb begin
      priority if (depth_ext == '0) begin
         new_last = '0;
      end else if (depth_ext > DW'(MAX_DEPTH)) begin
         new_last = IDX_W'(MAX_DEPTH - 1);
      end else begin
         new_last = IDX_W'(depth_ext - 1'b1);
      end
   end

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      wrapped_in = wrapped_ff;
      lapped_in  = lapped_ff;
      last_in    = last_ff;
      cmd        = '{strobe: 1'b0, mem_we: 1'b0, sel: SEL_ZERO, status: ST_OK};
      mem_addr   = head_ff;
      if (accept) begin
         cmd.strobe = 1'b1;
         unique case (req_op)
            OP_READ: begin
               if (empty) begin
                  cmd.sel    = SEL_EMPTY;
                  cmd.status = ST_RD_EMPTY;
               end else begin
                  cmd.sel = SEL_MEM;
                  head_in = head_next;
                  if (head_ff == last_ff) begin
                     wrapped_in = 1'b0;
                  end
               end
            end
            OP_WRITE: begin
               if (word_zero) begin
                  cmd.status = ST_ZERO_WR;
               end else begin
                  // Drop the oldest beat first when the ring is full.
                  if (full) begin
                     head_in    = head_next;
                     cmd.status = ST_DROPPED;
                     if (head_ff == last_ff) begin
                        wrapped_in = 1'b0;
                     end
                  end
                  mem_addr   = tail_ff;
                  cmd.mem_we = 1'b1;
                  cmd.sel    = lapped_ff ? SEL_MEM : SEL_ZERO;
                  tail_in    = tail_next;
                  if (tail_ff == last_ff) begin
                     wrapped_in = 1'b1;
                     lapped_in  = 1'b1;
                  end
               end
            end
            OP_CLEAR: begin
               head_in    = '0;
               tail_in    = '0;
               wrapped_in = 1'b0;
               lapped_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end
      if (csr_we) begin
         head_in    = '0;
         tail_in    = '0;
         wrapped_in = 1'b0;
         lapped_in  = 1'b0;
         last_in    = new_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         wrapped_ff <= 1'b0;
         lapped_ff  <= 1'b0;
         last_ff    <= IDX_W'(MAX_DEPTH - 1);
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         wrapped_ff <= wrapped_in;
         lapped_ff  <= lapped_in;
         last_ff    <= last_in;
      end
   end

   `ORF_ASSERT_SAME(a_ptr_range, clock, reset, 1'b1,
      (head_ff <= last_ff) && (tail_ff <= last_ff), "ring pointer beyond depth")
   `ORF_ASSERT_SAME(a_wrap_lapped, clock, reset, wrapped_ff, lapped_ff,
      "wrapped without tail lap")
   `ORF_ASSERT_NEXT(a_clear_empty, clock, reset, accept && (req_op == OP_CLEAR),
      (head_ff == tail_ff) && !wrapped_ff && !lapped_ff, "clear left ring nonempty")

endmodule

>>> rtl/orf_datapath.sv
// Ring FIFO datapath: slot memory, result registers and value select.
`include "overwriting_ring_fifo_unit_macros.svh"

module orf_datapath #(
   parameter int  MAX_DEPTH  = orf_pkg::MAX_DEPTH_DEF,
   parameter int  WORD_WIDTH = orf_pkg::WORD_WIDTH_DEF,
   localparam int IDX_W      = $clog2(MAX_DEPTH)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  orf_pkg::cmd_type               cmd,
   input  logic [IDX_W-1:0]               mem_addr,
   input  logic [WORD_WIDTH-1:0]          write_data,
   input  logic [WORD_WIDTH-1:0]          empty_value,
   output logic                           word_zero,
   output logic                           rsp_strobe,
   output logic [WORD_WIDTH-1:0]          rsp_value,
   output logic [orf_pkg::STATUS_W-1:0]   rsp_status
);
   import orf_pkg::*;

   logic [WORD_WIDTH-1:0] mem [MAX_DEPTH];
   logic [WORD_WIDTH-1:0] rd_data_ff, empty_ff;
   sel_type               sel_ff;
   logic [STATUS_W-1:0]   status_ff;
   logic                  strobe_ff;

   assign word_zero = (write_data == '0);

   // Read-first slot memory: a write returns the word the slot held.
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[mem_addr] <= write_data;
      end
      rd_data_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.strobe) begin
         sel_ff    <= cmd.sel;
         status_ff <= cmd.status;
         empty_ff  <= empty_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.strobe;
      end
   end

   always_comb begin
      unique case (sel_ff)
         SEL_MEM:   rsp_value = rd_data_ff;
         SEL_EMPTY: rsp_value = empty_ff;
         default:   rsp_value = '0;
      endcase
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;

   `ORF_ASSERT_NEXT(a_empty_value, clock, reset, cmd.strobe && (cmd.sel == SEL_EMPTY),
      rsp_strobe && (rsp_value == $past(empty_value)), "empty read lost empty value")

endmodule

>>> rtl/overwriting_ring_fifo_unit.sv
// Overwriting ring FIFO top level: controller plus slot datapath.
//
// Circular FIFO of up to MAX_DEPTH words that overwrites its oldest entry
// when full. Each item (start high, busy low) is a read, write or clear and
// gives exactly one result beat, shown on rsp_value/rsp_status for a single
// cycle with rsp_strobe, in the cycle after the item is taken. The receiver
// cannot stall: capture the beat when rsp_strobe is high or lose it. busy
// never rises, so an item may be issued every cycle; one slot-memory access
// per item (read-first at the head or tail) sets this pace.
// Writing csr_wdata (depth, 0 acts as 1, values above MAX_DEPTH clamp to it)
// empties the ring, as a clear does; write it only while no beat is pending.
module overwriting_ring_fifo_unit #(
   parameter int MAX_DEPTH  = orf_pkg::MAX_DEPTH_DEF,
   parameter int WORD_WIDTH = orf_pkg::WORD_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // Item channel
   input  logic                           start,
   output logic                           busy,
   input  logic [orf_pkg::OP_W-1:0]       req_op,
   input  logic [WORD_WIDTH-1:0]          req_write_data,
   input  logic [WORD_WIDTH-1:0]          req_empty_value,
   // Result channel
   output logic                           rsp_strobe,
   output logic [WORD_WIDTH-1:0]          rsp_value,
   output logic [orf_pkg::STATUS_W-1:0]   rsp_status,
   // Depth register
   input  logic                           csr_we,
   input  logic [orf_pkg::CSR_W-1:0]      csr_wdata
);
   import orf_pkg::*;

   localparam int IDX_W = $clog2(MAX_DEPTH);

   cmd_type          cmd;
   logic [IDX_W-1:0] mem_addr;
   logic             word_zero;

   // Decode the op, advance head/tail and issue one memory command a beat.
   orf_ctrl #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_op    (req_op),
      .word_zero (word_zero),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .mem_addr  (mem_addr)
   );

   // Hold the slots; register the read word and present the result beat.
   orf_datapath #(
      .MAX_DEPTH  (MAX_DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .mem_addr    (mem_addr),
      .write_data  (req_write_data),
      .empty_value (req_empty_value),
      .word_zero   (word_zero),
      .rsp_strobe  (rsp_strobe),
      .rsp_value   (rsp_value),
      .rsp_status  (rsp_status)
   );

endmodule
